// ----- hw/rtl/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LIFO stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int TOTAL_W   = 7;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISP = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

  // per-cycle move applied to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROT
  } cell_op_e;

endpackage

`default_nettype wire

// ----- hw/rtl/lse_if.sv -----
// ----------------------------------------------------------------------------
// lse_if
// Valid/ready channels of the LIFO stack engine: commands in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lse_cmd_if;
  import lse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

interface lse_rsp_if;
  import lse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data_word;
  logic [TOTAL_W-1:0]       entry_total;
  logic                     is_empty;
  logic                     last_of_run;

  modport source (output valid, output status, output data_word, output entry_total,
                  output is_empty, output last_of_run, input ready);
  modport sink   (input valid, input status, input data_word, input entry_total,
                  input is_empty, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lifo_stack_engine.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_engine
// LIFO stack of signed words kept in a chain of shifting cells; the top of
// the stack sits in cell 0 whenever no display walk is under way.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                           | words
//  cmd_if   | in  | cmd, push_value                                   | 1 per cmd
//  rsp_if   | out | status, data_word, entry_total, is_empty, last_of_run | 0..DEPTH
//
// Push and pop can follow back to back while results are taken; the chain shifts
// every cell in the same cycle. Display first starts the walk, then the chain
// rotates once per word emitted and is back in place after the last one.
// Reset clears the entry count and the control state; cell contents are kept.
// The result register stalls on rsp_if.ready; no command is taken during a
// display or while a result waits and is not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_engine
  import lse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lse_cmd_if.sink    cmd_if,
  lse_rsp_if.source  rsp_if
);

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } state_e;

  state_e               state_q;
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      rem_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic [DATA_W-1:0]    out_data_q;
  logic [CntW-1:0]      out_cnt_q;
  logic                 out_last_q;

  logic [DATA_W-1:0]    cell_data [DEPTH];
  cell_op_e             cell_op;
  logic                 slot_free;
  logic                 acc;
  logic                 full;
  logic                 empty;

  assign slot_free    = !out_valid_q || rsp_if.ready;
  assign cmd_if.ready = (state_q == ST_IDLE) && slot_free;
  assign acc          = cmd_if.valid && cmd_if.ready;
  assign full         = (cnt_q == CntW'(DEPTH));
  assign empty        = (cnt_q == '0);

  always_comb begin
    cell_op = CELL_HOLD;
    if (acc && cmd_if.cmd == CMD_PUSH && !full) begin
      cell_op = CELL_PUSH;
    end else if (acc && cmd_if.cmd == CMD_POP && !empty) begin
      cell_op = CELL_POP;
    end else if (state_q == ST_DISP && slot_free) begin
      cell_op = CELL_ROT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] up_w;
    logic [DATA_W-1:0] dn_w;

    if (i == 0) begin : g_head
      assign up_w = cmd_if.push_value;
    end else begin : g_body
      assign up_w = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign dn_w = '0;
    end else begin : g_mid
      assign dn_w = cell_data[i+1];
    end

    lse_cell #(
      .DataW (DATA_W)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .tail_i    (cnt_q == CntW'(i + 1)),
      .from_up_i (up_w),
      .from_dn_i (dn_w),
      .top_i     (cell_data[0]),
      .data_o    (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_data_q   <= '0;
      out_cnt_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (rsp_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (cmd_if.cmd)
              CMD_PUSH: begin
                out_valid_q <= 1'b1;
                out_last_q  <= 1'b1;
                if (full) begin
                  out_status_q <= STAT_OVER;
                  out_data_q   <= '0;
                  out_cnt_q    <= cnt_q;
                end else begin
                  out_status_q <= STAT_OK;
                  out_data_q   <= cmd_if.push_value;
                  out_cnt_q    <= cnt_q + 1'b1;
                  cnt_q        <= cnt_q + 1'b1;
                end
              end
              CMD_POP: begin
                out_valid_q <= 1'b1;
                out_last_q  <= 1'b1;
                if (empty) begin
                  out_status_q <= STAT_UNDER;
                  out_data_q   <= '0;
                  out_cnt_q    <= cnt_q;
                end else begin
                  out_status_q <= STAT_OK;
                  out_data_q   <= cell_data[0];
                  out_cnt_q    <= cnt_q - 1'b1;
                  cnt_q        <= cnt_q - 1'b1;
                end
              end
              CMD_DISP: begin
                if (empty) begin
                  out_valid_q  <= 1'b1;
                  out_last_q   <= 1'b1;
                  out_status_q <= STAT_EMPTY;
                  out_data_q   <= '0;
                  out_cnt_q    <= cnt_q;
                end else begin
                  rem_q   <= cnt_q;
                  state_q <= ST_DISP;
                end
              end
              default: ;  // unused code: dropped, no word
            endcase
          end
        end
        ST_DISP: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= STAT_OK;
            out_data_q   <= cell_data[0];
            out_cnt_q    <= cnt_q;
            out_last_q   <= (rem_q == CntW'(1));
            rem_q        <= rem_q - 1'b1;
            if (rem_q == CntW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.status      = out_status_q;
  assign rsp_if.data_word   = out_data_q;
  assign rsp_if.entry_total = TOTAL_W'(out_cnt_q);
  assign rsp_if.is_empty    = (out_cnt_q == '0);
  assign rsp_if.last_of_run = out_last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_disp_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DISP |-> (!empty && rem_q != '0 && !cmd_if.ready))
    else $error("display walk with no entries or open command port");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_if.cmd == CMD_PUSH && !full) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow the count");

  a_disp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP && slot_free && rem_q == CntW'(1)) |=>
      (state_q == ST_IDLE && out_valid_q && out_last_q))
    else $error("display walk did not end on a last word");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lse_cell.sv -----
// ----------------------------------------------------------------------------
// lse_cell
// One stack slot. Takes its word from the neighbor above (push), from the
// neighbor below (pop, rotate) or from the top cell when it is the tail of a
// rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_cell
  import lse_pkg::*;
#(
  parameter int DataW = DATA_W
) (
  input  wire logic              clk_i,
  input  wire cell_op_e          op_i,
  input  wire logic              tail_i,
  input  wire logic [DataW-1:0]  from_up_i,
  input  wire logic [DataW-1:0]  from_dn_i,
  input  wire logic [DataW-1:0]  top_i,
  output      logic [DataW-1:0]  data_o
);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_PUSH: data_d = from_up_i;
      CELL_POP:  data_d = from_dn_i;
      CELL_ROT:  data_d = tail_i ? top_i : from_dn_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lifo_stack_engine: drives push, pop and display
// commands, predicts every result word from a local copy of the stack and
// checks each result against the oldest prediction, across idle and stall mixes.
// ----------------------------------------------------------------------------

module tb;
  import lse_pkg::*;

  localparam int STACK_DEPTH  = DEPTH_DEF;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // code 3 is not a command; the block drops it
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_word;
    logic [TOTAL_W-1:0]  entry_total;
    logic                is_empty;
    logic                last_of_run;
  } stack_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  lse_cmd_if cmd_bus ();
  lse_rsp_if rsp_bus ();

  lifo_stack_engine u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_if (cmd_bus),
    .rsp_if (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the stack
  logic [DATA_W-1:0]  stack_words [STACK_DEPTH];
  logic [TOTAL_W-1:0] word_count = '0;
  stack_rsp_t         stack_results_q [$];

  int   send_idle_pct = 0;
  int   rsp_stall_pct = 0;
  int   mismatches    = 0;
  logic hold_req      = 1'b0;
  int   hold_left     = 0;

  function automatic void post_result(input logic [STATUS_W-1:0] st,
                                      input logic [DATA_W-1:0] word, input logic last);
    stack_rsp_t r;
    r.status      = st;
    r.data_word   = word;
    r.entry_total = word_count;
    r.is_empty    = (word_count == 0);
    r.last_of_run = last;
    stack_results_q.push_back(r);
  endfunction

  function automatic void stack_apply(input logic [CMD_W-1:0] op,
                                      input logic [DATA_W-1:0] value);
    int i;
    case (op)
      CMD_PUSH: begin
        if (word_count >= STACK_DEPTH) begin
          post_result(STAT_OVER, '0, 1'b1);
        end else begin
          stack_words[word_count] = value;
          word_count++;
          post_result(STAT_OK, value, 1'b1);
        end
      end
      CMD_POP: begin
        if (word_count == 0) begin
          post_result(STAT_UNDER, '0, 1'b1);
        end else begin
          word_count--;
          post_result(STAT_OK, stack_words[word_count], 1'b1);
        end
      end
      CMD_DISP: begin
        if (word_count == 0) begin
          post_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = word_count - 1; i >= 0; i--)
            post_result(STAT_OK, stack_words[i], i == 0);
        end
      end
      default: ;
    endcase
  endfunction

  // entered and left at a rising edge
  task automatic send_word(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= op;
    cmd_bus.push_value <= value;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    stack_apply(op, value);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    stack_rsp_t got;
    stack_rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got.status      = rsp_bus.status;
      got.data_word   = rsp_bus.data_word;
      got.entry_total = rsp_bus.entry_total;
      got.is_empty    = rsp_bus.is_empty;
      got.last_of_run = rsp_bus.last_of_run;
      if (stack_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: st=%0d data=%h total=%0d empty=%b last=%b",
                   got.status, got.data_word, got.entry_total, got.is_empty,
                   got.last_of_run);
      end else begin
        want = stack_results_q.pop_front();
        if (got.status !== want.status || got.data_word !== want.data_word ||
            got.entry_total !== want.entry_total || got.is_empty !== want.is_empty ||
            got.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp st=%0d data=%h total=%0d empty=%b last=%b",
                      " | got st=%0d data=%h total=%0d empty=%b last=%b"},
                     want.status, want.data_word, want.entry_total, want.is_empty,
                     want.last_of_run, got.status, got.data_word, got.entry_total,
                     got.is_empty, got.last_of_run);
        end
      end
    end
  end

  task automatic test_empty_stack();
    send_word(CMD_POP, 32'h1234_5678);
    send_word(CMD_DISP, 32'hFFFF_FFFF);
    send_word(CMD_NONE, 32'hDEAD_BEEF);
    send_word(CMD_POP, '0);
  endtask

  task automatic test_edge_values();
    send_word(CMD_PUSH, 32'h7FFF_FFFF);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_PUSH, 32'h0000_0000);
    send_word(CMD_PUSH, 32'hFFFF_FFFF);
    send_word(CMD_PUSH, 32'h0000_0001);
    send_word(CMD_DISP, '0);
    send_word(CMD_NONE, 32'h5555_AAAA);
    repeat (5) send_word(CMD_POP, 32'hAAAA_5555);
    send_word(CMD_POP, '0);
    send_word(CMD_DISP, '0);
  endtask

  task automatic test_full_stack();
    while (word_count < STACK_DEPTH) send_word(CMD_PUSH, pick_value());
    send_word(CMD_PUSH, 32'h7FFF_FFFF);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_DISP, '0);
    send_word(CMD_POP, '0);
    send_word(CMD_PUSH, pick_value());
    send_word(CMD_PUSH, pick_value());
  endtask

  // receiver holds off while commands keep coming
  task automatic test_backpressure();
    cmd_bus.valid <= 1'b0;
    hold_req      <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (4) send_word(CMD_PUSH, pick_value());
    send_word(CMD_DISP, '0);
    repeat (4) send_word(CMD_POP, '0);
  endtask

  // stretches of growth and shrinkage that turn near the full and empty ends
  task automatic test_random_mix(input int n_words);
    int   done = 0;
    int   r;
    logic growing = 1'b1;
    while (done < n_words) begin
      if (word_count >= STACK_DEPTH - 2 && $urandom_range(3) == 0) growing = 1'b0;
      if (word_count <= 1 && $urandom_range(3) == 0) growing = 1'b1;
      if ($urandom_range(19) == 0) growing = !growing;
      r = $urandom_range(99);
      if (r < 3) begin
        send_word(CMD_NONE, pick_value());
      end else if (r < 11) begin
        send_word(CMD_DISP, pick_value());
        done++;
      end else if ((r < 75) == growing) begin
        send_word(CMD_PUSH, pick_value());
        done++;
      end else begin
        send_word(CMD_POP, pick_value());
        done++;
      end
    end
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
  endtask

  initial begin
    rst_n              = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.cmd        = CMD_PUSH;
    cmd_bus.push_value = '0;
    rsp_bus.ready      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace(0, 0);
    test_empty_stack();
    test_edge_values();
    set_pace(30, 30);
    test_full_stack();
    set_pace(0, 0);
    test_backpressure();

    set_pace(0, 0);
    test_random_mix(4);
    set_pace(77, 0);
    test_random_mix(4);
    set_pace(0, 77);
    test_random_mix(4);
    set_pace(30, 30);
    test_random_mix(4);

    cmd_bus.valid <= 1'b0;
    while (stack_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
